@@ hw/rtl/lbc_pkg.sv @@
package lbc_pkg;

    localparam int DEF_NUM_WAYS   = 15;
    localparam int DEF_LINE_BYTES = 4096;
    localparam int DEF_ADDR_BITS  = 24;

    localparam int STAMP_W = 32;

    typedef logic [STAMP_W-1:0] t_stamp;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FILL    = 2'd1,
        ST_EXTEND  = 2'd2,
        ST_ILLEGAL = 2'd3
    } t_status;

endpackage

@@ hw/rtl/line_buffer_cache_lru_control_top.sv @@
// Control of a fully associative write-back line cache with LRU replacement.
// One transaction per cycle is sustained unless the output stalls: an access is
// captured in the input register and, when the result register is free, the
// parallel tag compare over all ways, the use-stamp minimum tree and the state
// update run in one pass into the result register, so the access that follows
// already sees the updated tags, dirty bits and stamps. Status codes: hit,
// miss with fill, miss that extends the store end (no fill needed), and
// illegal (line base beyond the end; nothing changes). A dirty victim raises
// writeback with its base. Use stamps saturate at the 32-bit maximum; ties
// then go to the lowest way. LINE_BYTES must be a power of two.
module line_buffer_cache_lru_control_top #(
    parameter int NUM_WAYS   = lbc_pkg::DEF_NUM_WAYS,
    parameter int LINE_BYTES = lbc_pkg::DEF_LINE_BYTES,
    parameter int ADDR_BITS  = lbc_pkg::DEF_ADDR_BITS,
    localparam int WAY_W     = $clog2(NUM_WAYS),
    localparam int OFF_W     = $clog2(LINE_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [ADDR_BITS-1:0] i_position,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lbc_pkg::t_status     o_status,
    output logic [WAY_W-1:0]     o_way,
    output logic [OFF_W-1:0]     o_offset,
    output logic                 o_writeback,
    output logic [ADDR_BITS-1:0] o_writeback_base,
    output logic [ADDR_BITS-1:0] o_fill_base
);
    import lbc_pkg::*;

    localparam int LNUM_W = ADDR_BITS - OFF_W;
    localparam int END_W  = ADDR_BITS + 1;

    // input register
    logic                 r_in_valid;
    logic                 r_func;
    logic [ADDR_BITS-1:0] r_pos;

    // cache state
    logic [LNUM_W-1:0]   r_base [NUM_WAYS];
    logic [NUM_WAYS-1:0] r_valid;
    logic [NUM_WAYS-1:0] r_dirty;
    t_stamp              r_stamp [NUM_WAYS];
    t_stamp              r_clock;
    logic [END_W-1:0]    r_end;

    // result register
    logic                 r_out_valid;
    t_status              r_status;
    logic [WAY_W-1:0]     r_way;
    logic [OFF_W-1:0]     r_offset;
    logic                 r_wb;
    logic [ADDR_BITS-1:0] r_wb_base;
    logic [ADDR_BITS-1:0] r_fill_base;

    logic                 w_take;
    logic [LNUM_W-1:0]    w_lnum;
    logic [OFF_W-1:0]     w_offset;
    logic [ADDR_BITS-1:0] w_base;
    logic                 w_hit;
    logic [WAY_W-1:0]     w_hit_way;
    logic [WAY_W-1:0]     w_victim;
    logic [WAY_W-1:0]     w_way;
    logic                 w_illegal;
    logic                 w_extend;
    logic                 w_miss;
    logic                 w_wb;
    t_stamp               n_clock;
    t_status              n_status;

    assign w_take     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func <= i_func;
            r_pos  <= i_position;
        end
    end

    assign w_lnum   = r_pos[ADDR_BITS-1:OFF_W];
    assign w_offset = r_pos[OFF_W-1:0];
    assign w_base   = {w_lnum, {OFF_W{1'b0}}};

    lbc_lookup #(
        .NUM_WAYS (NUM_WAYS),
        .LNUM_W   (LNUM_W)
    ) u_lookup (
        .i_base  (r_base),
        .i_valid (r_valid),
        .i_lnum  (w_lnum),
        .o_hit   (w_hit),
        .o_way   (w_hit_way)
    );

    lbc_victim #(
        .NUM_WAYS (NUM_WAYS)
    ) u_victim (
        .i_stamp (r_stamp),
        .o_way   (w_victim)
    );

    assign w_illegal = !w_hit && ({1'b0, w_base} > r_end);
    assign w_extend  = !w_hit && ({1'b0, w_base} == r_end);
    assign w_miss    = !w_hit && !w_illegal;
    assign w_way     = w_hit ? w_hit_way : w_victim;
    assign w_wb      = w_miss && r_valid[w_victim] && r_dirty[w_victim];
    assign n_clock   = (&r_clock) ? r_clock : r_clock + 1'b1;

    always_comb begin
        if (w_illegal) begin
            n_status = ST_ILLEGAL;
        end else if (w_hit) begin
            n_status = ST_HIT;
        end else if (w_extend) begin
            n_status = ST_EXTEND;
        end else begin
            n_status = ST_FILL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_clock <= '0;
            r_end   <= '0;
            for (int i = 0; i < NUM_WAYS; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (w_take && !w_illegal) begin
            r_clock        <= n_clock;
            r_stamp[w_way] <= n_clock;
            if (w_hit) begin
                if (r_func) begin
                    r_dirty[w_way] <= 1'b1;
                end
            end else begin
                r_valid[w_way] <= 1'b1;
                r_dirty[w_way] <= r_func;
                if (w_extend) begin
                    r_end <= r_end + END_W'(LINE_BYTES);
                end
            end
        end
    end

    // tags are only read behind a valid bit
    always_ff @(posedge i_clk) begin
        if (w_take && w_miss) begin
            r_base[w_victim] <= w_lnum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status    <= n_status;
            r_way       <= w_illegal ? '0 : w_way;
            r_offset    <= w_illegal ? '0 : w_offset;
            r_wb        <= w_wb;
            r_wb_base   <= w_wb ? {r_base[w_victim], {OFF_W{1'b0}}} : '0;
            r_fill_base <= w_miss ? w_base : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_way            = r_way;
    assign o_offset         = r_offset;
    assign o_writeback      = r_wb;
    assign o_writeback_base = r_wb_base;
    assign o_fill_base      = r_fill_base;

endmodule

@@ hw/rtl/lbc_lookup.sv @@
module lbc_lookup #(
    parameter int NUM_WAYS = lbc_pkg::DEF_NUM_WAYS,
    parameter int LNUM_W   = lbc_pkg::DEF_ADDR_BITS - $clog2(lbc_pkg::DEF_LINE_BYTES),
    localparam int WAY_W   = $clog2(NUM_WAYS)
) (
    input  logic [LNUM_W-1:0] i_base [NUM_WAYS],
    input  logic [NUM_WAYS-1:0] i_valid,
    input  logic [LNUM_W-1:0] i_lnum,
    output logic               o_hit,
    output logic [WAY_W-1:0]   o_way
);
    import lbc_pkg::*;

    // parallel tag compare; lowest matching way wins
    always_comb begin
        o_hit = 1'b0;
        o_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_base[i] == i_lnum)) begin
                o_hit = 1'b1;
                o_way = WAY_W'(i);
            end
        end
    end

endmodule

@@ hw/rtl/lbc_victim.sv @@
module lbc_victim #(
    parameter int NUM_WAYS = lbc_pkg::DEF_NUM_WAYS,
    localparam int WAY_W   = $clog2(NUM_WAYS)
) (
    input  lbc_pkg::t_stamp  i_stamp [NUM_WAYS],
    output logic [WAY_W-1:0] o_way
);
    import lbc_pkg::*;

    localparam int LEAVES = 1 << WAY_W;
    localparam int NODES  = 2 * LEAVES - 1;

    t_stamp           node_s [NODES];
    logic [WAY_W-1:0] node_i [NODES];

    // min tree over use stamps; left side wins ties so the lowest index is kept.
    // Padding leaves sit at the tail with the maximum stamp and never win.
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            if (i < NUM_WAYS) begin
                node_s[LEAVES - 1 + i] = i_stamp[i];
                node_i[LEAVES - 1 + i] = WAY_W'(i);
            end else begin
                node_s[LEAVES - 1 + i] = '1;
                node_i[LEAVES - 1 + i] = '0;
            end
        end
        for (int k = LEAVES - 2; k >= 0; k--) begin
            if (node_s[2*k+1] <= node_s[2*k+2]) begin
                node_s[k] = node_s[2*k+1];
                node_i[k] = node_i[2*k+1];
            end else begin
                node_s[k] = node_s[2*k+2];
                node_i[k] = node_i[2*k+2];
            end
        end
        o_way = node_i[0];
    end

endmodule

@@ hw/rtl/lbc_checker.sv @@
module lbc_checker #(
    parameter int NUM_WAYS   = lbc_pkg::DEF_NUM_WAYS,
    parameter int LINE_BYTES = lbc_pkg::DEF_LINE_BYTES,
    parameter int ADDR_BITS  = lbc_pkg::DEF_ADDR_BITS,
    localparam int WAY_W     = $clog2(NUM_WAYS),
    localparam int OFF_W     = $clog2(LINE_BYTES)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input lbc_pkg::t_status     i_status,
    input logic [WAY_W-1:0]     i_way,
    input logic [OFF_W-1:0]     i_offset,
    input logic                 i_writeback,
    input logic [ADDR_BITS-1:0] i_writeback_base,
    input logic [ADDR_BITS-1:0] i_fill_base
);
    import lbc_pkg::*;

    // stalled result transaction stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_way) && $stable(i_fill_base))
        else $error("result dropped or changed while stalled");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ILLEGAL) |-> (i_way == '0) && (i_offset == '0)
            && !i_writeback && (i_writeback_base == '0) && (i_fill_base == '0))
        else $error("illegal access reported nonzero fields");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_HIT) |-> !i_writeback && (i_fill_base == '0))
        else $error("hit reported writeback or fill");

    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_writeback |-> (i_status == ST_FILL) || (i_status == ST_EXTEND))
        else $error("writeback without miss");

    a_fill_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fill_base[OFF_W-1:0] == '0) && (i_writeback_base[OFF_W-1:0] == '0))
        else $error("line base not aligned");

endmodule

bind line_buffer_cache_lru_control_top lbc_checker #(
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
) u_lbc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .i_status         (o_status),
    .i_way            (o_way),
    .i_offset         (o_offset),
    .i_writeback      (o_writeback),
    .i_writeback_base (o_writeback_base),
    .i_fill_base      (o_fill_base)
);
